[src/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the triangle plane splitter
// Holds state types, register indexes, default widths and width helpers.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_IDX_BITS   = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_A = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_B = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_C = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_D = 4'd3;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DEN,
        B_DSUM,
        B_START,
        B_LOAD,
        B_MUL,
        B_DIV,
        B_FIN,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // width of an exact plane value
    function automatic int sum_width(input int c, input int f);
        return ((2 * c > c + f) ? 2 * c : c + f) + 2;
    endfunction

    // width of one queue entry: vertices, color, plane value, mode
    function automatic int entry_width(input int c, input int f);
        return 9 * c + COLOR_BITS + sum_width(c, f) + 1;
    endfunction

endpackage

[src/triangle_plane_splitter.sv]
// ----------------------------------------------------------------------------
// triangle_plane_splitter: splits triangles against a configured plane
// A classifier and an edge splitter joined by a two-entry queue.
// ----------------------------------------------------------------------------
// A triangle is classified and then waits in a two-entry queue, so the
// input is ready again while earlier triangles are still being split. The
// splitter sets the rate: each cut coordinate runs through a shift-add
// multiplier and a restoring divider, one quotient bit a cycle. A two-piece
// triangle costs one edge, a three-piece triangle two, and a parallel edge
// ends the triangle at once with a single dropped result. Results leave
// through an output register that holds while m_ready is low. The plane
// registers take writes in every cycle and must only change while idle.
module triangle_plane_splitter #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_BITS-1:0]          s_in_v0_x,
    input  logic signed [COORD_BITS-1:0]          s_in_v0_y,
    input  logic signed [COORD_BITS-1:0]          s_in_v0_z,
    input  logic signed [COORD_BITS-1:0]          s_in_v1_x,
    input  logic signed [COORD_BITS-1:0]          s_in_v1_y,
    input  logic signed [COORD_BITS-1:0]          s_in_v1_z,
    input  logic signed [COORD_BITS-1:0]          s_in_v2_x,
    input  logic signed [COORD_BITS-1:0]          s_in_v2_y,
    input  logic signed [COORD_BITS-1:0]          s_in_v2_z,
    input  logic [tps_pkg::COLOR_BITS-1:0]        s_in_color,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [COORD_BITS-1:0]          m_out_v0_x,
    output logic signed [COORD_BITS-1:0]          m_out_v0_y,
    output logic signed [COORD_BITS-1:0]          m_out_v0_z,
    output logic signed [COORD_BITS-1:0]          m_out_v1_x,
    output logic signed [COORD_BITS-1:0]          m_out_v1_y,
    output logic signed [COORD_BITS-1:0]          m_out_v1_z,
    output logic signed [COORD_BITS-1:0]          m_out_v2_x,
    output logic signed [COORD_BITS-1:0]          m_out_v2_y,
    output logic signed [COORD_BITS-1:0]          m_out_v2_z,
    output logic [tps_pkg::COLOR_BITS-1:0]        m_out_color,
    output logic                                  m_piece_last,
    output logic                                  m_dropped
);
    localparam int QW = tps_pkg::entry_width(COORD_BITS, FRAC_BITS);

    logic signed [COORD_BITS-1:0] plane_reg [4];
    logic signed [COORD_BITS-1:0] in_vert [3][3];
    logic signed [COORD_BITS-1:0] out_vert [3][3];
    logic [QW-1:0]                wr_data, rd_data;
    logic                         q_push, q_pop;
    tps_pkg::q_stat_t             q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg[0] <= '0;
            plane_reg[1] <= '0;
            plane_reg[2] <= COORD_BITS'(1) <<< FRAC_BITS;
            plane_reg[3] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tps_pkg::CFG_PLANE_A: plane_reg[0] <= cfg_data;
                tps_pkg::CFG_PLANE_B: plane_reg[1] <= cfg_data;
                tps_pkg::CFG_PLANE_C: plane_reg[2] <= cfg_data;
                tps_pkg::CFG_PLANE_D: plane_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_vert[0][0] = s_in_v0_x;
    assign in_vert[0][1] = s_in_v0_y;
    assign in_vert[0][2] = s_in_v0_z;
    assign in_vert[1][0] = s_in_v1_x;
    assign in_vert[1][1] = s_in_v1_y;
    assign in_vert[1][2] = s_in_v1_z;
    assign in_vert[2][0] = s_in_v2_x;
    assign in_vert[2][1] = s_in_v2_y;
    assign in_vert[2][2] = s_in_v2_z;

    tps_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .in_vert  (in_vert),
        .in_color (s_in_color),
        .plane    (plane_reg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (wr_data)
    );

    tps_queue #(.WIDTH(QW), .DEPTH(tps_pkg::QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (wr_data),
        .pop     (q_pop),
        .rd_data (rd_data),
        .stat    (q_stat)
    );

    tps_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .plane       (plane_reg),
        .q_stat      (q_stat),
        .q_data      (rd_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .out_vert    (out_vert),
        .out_color   (m_out_color),
        .out_last    (m_piece_last),
        .out_dropped (m_dropped)
    );

    assign m_out_v0_x = out_vert[0][0];
    assign m_out_v0_y = out_vert[0][1];
    assign m_out_v0_z = out_vert[0][2];
    assign m_out_v1_x = out_vert[1][0];
    assign m_out_v1_y = out_vert[1][1];
    assign m_out_v1_z = out_vert[1][2];
    assign m_out_v2_x = out_vert[2][0];
    assign m_out_v2_y = out_vert[2][1];
    assign m_out_v2_z = out_vert[2][2];

endmodule

[src/tps_queue.sv]
// ----------------------------------------------------------------------------
// tps_queue: short queue between classifier and splitter
// Register based first-in first-out store with full and empty status.
// ----------------------------------------------------------------------------
module tps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tps_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  rd_data,
    output tps_pkg::q_stat_t  stat
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/tps_front.sv]
// ----------------------------------------------------------------------------
// tps_front: triangle classifier
// Forms the exact plane value of each vertex, picks the split case and
// orders the vertices for the splitter.
// ----------------------------------------------------------------------------
module tps_front #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_BITS-1:0]          in_vert [3][3],
    input  logic [tps_pkg::COLOR_BITS-1:0]        in_color,
    input  logic signed [COORD_BITS-1:0]          plane [4],
    input  tps_pkg::q_stat_t                      q_stat,
    output logic                                  q_push,
    output logic [tps_pkg::entry_width(COORD_BITS, FRAC_BITS)-1:0] q_data
);
    localparam int C  = COORD_BITS;
    localparam int SW = tps_pkg::sum_width(COORD_BITS, FRAC_BITS);
    localparam int PW = 2 * C;
    localparam int CB = tps_pkg::COLOR_BITS;

    tps_pkg::front_state_t state_reg, state_next;

    logic signed [C-1:0]  tri_reg [3][3];
    logic [CB-1:0]        color_reg;
    logic [1:0]           cnt_reg;
    logic signed [PW-1:0] prod_reg [3];
    logic signed [SW-1:0] s_reg [3];

    logic [2:0]           zero, neg;
    logic [1:0]           i0, i1, i2;
    logic                 two;
    logic signed [SW-1:0] sp;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tps_pkg::F_IDLE: begin
                if (s_valid) state_next = tps_pkg::F_CALC;
            end
            tps_pkg::F_CALC: begin
                if (cnt_reg == 2'd3) state_next = tps_pkg::F_PUSH;
            end
            tps_pkg::F_PUSH: begin
                if (!q_stat.full) state_next = tps_pkg::F_IDLE;
            end
            default: state_next = tps_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == tps_pkg::F_IDLE);
        q_push  = (state_reg == tps_pkg::F_PUSH) && !q_stat.full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tps_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_valid && s_ready) begin
            cnt_reg <= '0;
        end else if (state_reg == tps_pkg::F_CALC) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    // one vertex per cycle through the three multipliers, summed in the cycle after
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tri_reg   <= in_vert;
            color_reg <= in_color;
        end
        if (state_reg == tps_pkg::F_CALC) begin
            if (cnt_reg != 2'd3) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[k] <= PW'(plane[k]) * PW'(tri_reg[cnt_reg][k]);
                end
            end
            if (cnt_reg != 2'd0) begin
                s_reg[cnt_reg - 2'd1] <= SW'(prod_reg[0]) + SW'(prod_reg[1])
                                       + SW'(prod_reg[2]) + (SW'(plane[3]) <<< FRAC_BITS);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            zero[i] = (s_reg[i] == '0);
            neg[i]  = s_reg[i][SW-1];
        end
        two = 1'b1;
        i0 = 2'd0; i1 = 2'd1; i2 = 2'd2;
        if (zero[0]) begin
            i0 = 2'd0; i1 = 2'd1; i2 = 2'd2;
        end else if (zero[1]) begin
            i0 = 2'd1; i1 = 2'd0; i2 = 2'd2;
        end else if (zero[2]) begin
            i0 = 2'd2; i1 = 2'd0; i2 = 2'd1;
        end else begin
            two = 1'b0;
            // lone vertex first, then the pair on the other side
            if (neg[0] == neg[1]) begin
                i0 = 2'd2; i1 = 2'd0; i2 = 2'd1;
            end else if (neg[1] == neg[2]) begin
                i0 = 2'd0; i1 = 2'd1; i2 = 2'd2;
            end else begin
                i0 = 2'd1; i1 = 2'd0; i2 = 2'd2;
            end
        end
        sp = two ? s_reg[i1] : s_reg[i0];
        for (int k = 0; k < 3; k++) begin
            q_data[k*C +: C]       = tri_reg[i0][k];
            q_data[(3+k)*C +: C]   = tri_reg[i1][k];
            q_data[(6+k)*C +: C]   = tri_reg[i2][k];
        end
        q_data[9*C +: CB]           = color_reg;
        q_data[9*C+CB +: SW]        = sp;
        q_data[9*C+CB+SW]           = two;
    end

endmodule

[src/tps_back.sv]
// ----------------------------------------------------------------------------
// tps_back: edge intersection and piece output
// Computes edge cuts with a shift-add multiplier and a restoring divider,
// saturates them and sends the pieces through the output register.
// ----------------------------------------------------------------------------
module tps_back #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [COORD_BITS-1:0]          plane [4],
    input  tps_pkg::q_stat_t                      q_stat,
    input  logic [tps_pkg::entry_width(COORD_BITS, FRAC_BITS)-1:0] q_data,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [COORD_BITS-1:0]          out_vert [3][3],
    output logic [tps_pkg::COLOR_BITS-1:0]        out_color,
    output logic                                  out_last,
    output logic                                  out_dropped
);
    localparam int C    = COORD_BITS;
    localparam int CB   = tps_pkg::COLOR_BITS;
    localparam int SW   = tps_pkg::sum_width(COORD_BITS, FRAC_BITS);
    localparam int DPW  = 2 * C + 1;
    localparam int DW   = 2 * C + 3;
    localparam int NUMW = SW + C + 1;
    localparam int RW   = NUMW + 2;
    localparam int STB  = $clog2(NUMW);

    tps_pkg::back_state_t state_reg, state_next;

    logic signed [C-1:0]   pv_reg [3][3];
    logic [CB-1:0]         color_reg;
    logic                  two_reg;
    logic signed [SW-1:0]  sp_reg;
    logic                  edge_reg;
    logic [1:0]            k_reg;
    logic [1:0]            piece_reg;
    logic signed [DPW-1:0] dprod_reg [3];
    logic signed [DW-1:0]  den_reg;
    logic [DW-1:0]         dabs_reg;
    logic                  drop_reg;
    logic                  qneg_reg;
    logic [STB-1:0]        step_reg;
    logic [NUMW-1:0]       acc_reg, mcand_reg;
    logic [C:0]            mplier_reg;
    logic [DW-1:0]         rem_reg;
    logic signed [C-1:0]   cut_reg [2][3];

    logic signed [C-1:0]   out_vert_reg [3][3];
    logic [CB-1:0]         out_color_reg;
    logic                  out_last_reg, out_drop_reg, out_valid_reg;

    logic signed [C-1:0]   ep [3], eq [3];
    logic signed [C:0]     dv [3];
    logic [C:0]            dv_abs;
    logic [SW-1:0]         sp_abs;
    logic [DW:0]           trial;
    logic                  qbit;
    logic signed [NUMW:0]  off;
    logic signed [RW-1:0]  res;
    logic signed [C-1:0]   sat;
    logic signed [C-1:0]   pc [3][3];
    logic                  last;
    logic                  out_load;

    // edge endpoints: two-piece cuts v1-v2, three-piece cuts lone-a and lone-b
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ep[k] = (two_reg && !edge_reg) ? pv_reg[1][k] : pv_reg[0][k];
            eq[k] = (!two_reg && !edge_reg) ? pv_reg[1][k] : pv_reg[2][k];
            dv[k] = (C+1)'(eq[k]) - (C+1)'(ep[k]);
        end
        dv_abs = dv[k_reg][C] ? (C+1)'(-dv[k_reg]) : dv[k_reg];
        sp_abs = sp_reg[SW-1] ? SW'(-sp_reg) : sp_reg;
        trial  = {rem_reg, acc_reg[NUMW-1]};
        qbit   = (trial >= (DW+1)'(dabs_reg));
        off    = qneg_reg ? -(NUMW+1)'(acc_reg) : (NUMW+1)'(acc_reg);
        res    = RW'(ep[k_reg]) + RW'(off);
        if (!res[RW-1] && (|res[RW-2:C-1])) begin
            sat = {1'b0, {(C-1){1'b1}}};
        end else if (res[RW-1] && !(&res[RW-2:C-1])) begin
            sat = {1'b1, {(C-1){1'b0}}};
        end else begin
            sat = res[C-1:0];
        end
    end

    always_comb begin
        last     = drop_reg || (two_reg ? (piece_reg == 2'd1) : (piece_reg == 2'd2));
        out_load = (state_reg == tps_pkg::B_EMIT) && (!out_valid_reg || m_ready);
        q_pop    = (state_reg == tps_pkg::B_IDLE) && !q_stat.empty;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tps_pkg::B_IDLE:  if (!q_stat.empty) state_next = tps_pkg::B_DEN;
            tps_pkg::B_DEN:   state_next = tps_pkg::B_DSUM;
            tps_pkg::B_DSUM:  state_next = tps_pkg::B_START;
            tps_pkg::B_START: state_next = (den_reg == '0) ? tps_pkg::B_EMIT : tps_pkg::B_LOAD;
            tps_pkg::B_LOAD:  state_next = tps_pkg::B_MUL;
            tps_pkg::B_MUL:   if (step_reg == STB'(C)) state_next = tps_pkg::B_DIV;
            tps_pkg::B_DIV:   if (step_reg == STB'(NUMW - 1)) state_next = tps_pkg::B_FIN;
            tps_pkg::B_FIN: begin
                if (k_reg != 2'd2) begin
                    state_next = tps_pkg::B_LOAD;
                end else if (!two_reg && !edge_reg) begin
                    state_next = tps_pkg::B_DEN;
                end else begin
                    state_next = tps_pkg::B_EMIT;
                end
            end
            tps_pkg::B_EMIT:  if (out_load && last) state_next = tps_pkg::B_IDLE;
            default:          state_next = tps_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tps_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tps_pkg::B_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    pv_reg[0][k] <= q_data[k*C +: C];
                    pv_reg[1][k] <= q_data[(3+k)*C +: C];
                    pv_reg[2][k] <= q_data[(6+k)*C +: C];
                end
                color_reg <= q_data[9*C +: CB];
                sp_reg    <= q_data[9*C+CB +: SW];
                two_reg   <= q_data[9*C+CB+SW];
                edge_reg  <= 1'b0;
                drop_reg  <= 1'b0;
            end
            tps_pkg::B_DEN: begin
                for (int k = 0; k < 3; k++) begin
                    dprod_reg[k] <= DPW'(plane[k]) * DPW'(dv[k]);
                end
            end
            tps_pkg::B_DSUM: begin
                den_reg <= DW'(dprod_reg[0]) + DW'(dprod_reg[1]) + DW'(dprod_reg[2]);
            end
            tps_pkg::B_START: begin
                dabs_reg  <= den_reg[DW-1] ? DW'(-den_reg) : den_reg;
                drop_reg  <= (den_reg == '0);
                k_reg     <= 2'd0;
                piece_reg <= 2'd0;
            end
            tps_pkg::B_LOAD: begin
                acc_reg    <= '0;
                mcand_reg  <= NUMW'(sp_abs);
                mplier_reg <= dv_abs;
                // the numerator is the negated plane value of the edge start
                qneg_reg   <= (!sp_reg[SW-1]) ^ dv[k_reg][C] ^ den_reg[DW-1];
                step_reg   <= '0;
            end
            tps_pkg::B_MUL: begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                rem_reg    <= '0;
                step_reg   <= (step_reg == STB'(C)) ? '0 : step_reg + 1'b1;
            end
            tps_pkg::B_DIV: begin
                // quotient bits shift in where the dividend shifts out
                rem_reg  <= qbit ? DW'(trial - (DW+1)'(dabs_reg)) : DW'(trial);
                acc_reg  <= {acc_reg[NUMW-2:0], qbit};
                step_reg <= step_reg + 1'b1;
            end
            tps_pkg::B_FIN: begin
                cut_reg[edge_reg][k_reg] <= sat;
                if (k_reg != 2'd2) begin
                    k_reg <= k_reg + 2'd1;
                end else begin
                    k_reg    <= 2'd0;
                    edge_reg <= 1'b1;
                end
                piece_reg <= 2'd0;
            end
            tps_pkg::B_EMIT: begin
                if (out_load) piece_reg <= piece_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pc[0][k] = pv_reg[0][k];
            pc[1][k] = cut_reg[0][k];
            pc[2][k] = cut_reg[1][k];
            if (drop_reg) begin
                pc[0][k] = '0;
                pc[1][k] = '0;
                pc[2][k] = '0;
            end else if (two_reg) begin
                pc[2][k] = (piece_reg == 2'd0) ? pv_reg[1][k] : pv_reg[2][k];
            end else begin
                case (piece_reg)
                    2'd0: pc[0][k] = pv_reg[0][k];
                    2'd1: pc[0][k] = pv_reg[1][k];
                    default: begin
                        pc[0][k] = cut_reg[1][k];
                        pc[1][k] = pv_reg[1][k];
                        pc[2][k] = pv_reg[2][k];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_vert_reg  <= pc;
            out_color_reg <= color_reg;
            out_last_reg  <= last;
            out_drop_reg  <= drop_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign out_vert    = out_vert_reg;
    assign out_color   = out_color_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_drop_reg;

endmodule

[src/tps_checker.sv]
// ----------------------------------------------------------------------------
// tps_checker: port level checks of the triangle plane splitter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_BITS-1:0]  m_out_v0_x,
    input logic signed [COORD_BITS-1:0]  m_out_v0_y,
    input logic signed [COORD_BITS-1:0]  m_out_v0_z,
    input logic signed [COORD_BITS-1:0]  m_out_v1_x,
    input logic signed [COORD_BITS-1:0]  m_out_v1_y,
    input logic signed [COORD_BITS-1:0]  m_out_v1_z,
    input logic signed [COORD_BITS-1:0]  m_out_v2_x,
    input logic signed [COORD_BITS-1:0]  m_out_v2_y,
    input logic signed [COORD_BITS-1:0]  m_out_v2_z,
    input logic [tps_pkg::COLOR_BITS-1:0] m_out_color,
    input logic                          m_piece_last,
    input logic                          m_dropped
);

    // a dropped triangle yields exactly one result, so it must be marked last
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_piece_last)
        else $error("dropped result not marked last");

    // a dropped result carries no geometry
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> (m_out_v0_x == '0) && (m_out_v0_y == '0)
            && (m_out_v0_z == '0) && (m_out_v1_x == '0) && (m_out_v1_y == '0)
            && (m_out_v1_z == '0) && (m_out_v2_x == '0) && (m_out_v2_y == '0)
            && (m_out_v2_z == '0))
        else $error("dropped result with nonzero coordinates");

    // stalled transaction holds its valid, color, flags and first x coordinate
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_color)
            && $stable(m_piece_last) && $stable(m_dropped) && $stable(m_out_v0_x))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind triangle_plane_splitter tps_checker #(.COORD_BITS(COORD_BITS)) u_tps_checker (.*);
